FILE: hdl/sorted_insert_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// sorted insert priority queue assertion macros
// shared concurrent assertion forms for the queue's checks
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define SPIQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spiq same-cycle check failed");

// condition holds in the following cycle
`define SPIQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spiq next-cycle check failed");

`endif

FILE: hdl/spiq_pkg.sv
// ----------------------------------------------------------------------------
// spiq_pkg
// types and codes shared by the sorted insert priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spiq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int TAG_W         = 16;
   localparam int SCORE_W       = 24;
   localparam int COUNT_OUT_W   = 5;
   localparam int STATUS_W      = 2;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 48;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic        [TAG_W-1:0]   tag;
      logic signed [SCORE_W-1:0] score;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: hdl/sorted_insert_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit
// bounded priority queue kept in ascending score order in a chain of cells
// ----------------------------------------------------------------------------
// On each accepted request every cell compares its stored score with the
// new one and either keeps its entry, loads the new entry or takes its
// neighbor's, so the work of an insert or a remove of the head does not
// grow with DEPTH. The result is held in an output register until
// taken; a new request is accepted in any cycle where that register is empty
// or is being drained, so back-to-back requests run at one per cycle.
// Among equal scores the newest entry sits nearest the head.
`default_nettype none

module sorted_insert_priority_queue_unit
   import spiq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] entry_tag, [39:16] entry_score
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [4:0] entry_count, [5] is_full, [6] is_empty, [22:7] head_tag,
   // [46:23] head_score, [47] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [STATUS_W-1:0]        rsp_tuser
);

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         status_ff;
   status_type         status_in;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   cell_ctrl_type      ctrl;
   entry_type          cell_entry [DEPTH];
   logic               cell_keep  [DEPTH];
   logic [COUNT_W+COUNT_OUT_W-1:0] count_wide;
   entry_type          head;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == FULL_COUNT);
   assign is_empty   = (count_ff == '0);

   assign ctrl.insert      = accept && (req_kind_type'(req_tuser) == REQ_INSERT) && !is_full;
   assign ctrl.remove      = accept && (req_kind_type'(req_tuser) == REQ_REMOVE) && !is_empty;
   assign ctrl.entry.tag   = req_tdata[TAG_W-1:0];
   assign ctrl.entry.score = req_tdata[TAG_W+SCORE_W-1:TAG_W];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      prev_keep;
      entry_type prev_entry;
      entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_keep  = 1'b1;
         assign prev_entry = ctrl.entry;
      end else begin : g_mid
         assign prev_keep  = cell_keep[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      spiq_cell #(
         .INDEX   (i),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock      (clock),
         .count      (count_ff),
         .ctrl       (ctrl),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .keep       (cell_keep[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_DONE;
         if (req_kind_type'(req_tuser) == REQ_INSERT) begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_DONE;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign head       = is_empty ? '0 : cell_entry[0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, head.score, head.tag, is_empty, is_full,
                        count_wide[COUNT_OUT_W-1:0]};

`include "sorted_insert_priority_queue_unit_assert.svh"

   `SPIQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `SPIQ_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.insert,
                     count_ff == $past(count_ff) + COUNT_W'(1))
   `SPIQ_ASSERT_NEXT(a_remove_shrinks, clock, reset, ctrl.remove,
                     count_ff == $past(count_ff) - COUNT_W'(1))
   `SPIQ_ASSERT_SAME(a_head_sorted, clock, reset, count_ff >= COUNT_W'(2),
                     $signed(cell_entry[0].score) <= $signed(cell_entry[1].score))
   `SPIQ_ASSERT_SAME(a_full_status, clock, reset,
                     rsp_valid_ff && (status_ff == ST_FULL), is_full)

endmodule

`default_nettype wire

FILE: hdl/spiq_cell.sv
// ----------------------------------------------------------------------------
// spiq_cell
// one slot of the sorted chain: keeps, loads the new entry, or shifts
// ----------------------------------------------------------------------------
`default_nettype none

module spiq_cell
   import spiq_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  wire logic                clock,
   input  wire logic [COUNT_W-1:0]  count,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic                prev_keep,
   input  wire entry_type           prev_entry,
   input  wire entry_type           next_entry,
   output entry_type                entry,
   output logic                     keep
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;

   assign occupied = (count > COUNT_W'(INDEX));
   assign keep     = occupied && ($signed(entry_ff.score) < $signed(ctrl.entry.score));
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!keep) begin
            entry_in = prev_keep ? ctrl.entry : prev_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: sim/sorted_insert_priority_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit_tb
// streams insert and remove requests into the queue, keeps a sorted model of
// its contents and checks status, count, flags and head entry of each result
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue_unit_tb
   import spiq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;

   typedef struct packed {
      logic                      pad;
      logic signed [SCORE_W-1:0] head_score;
      logic        [TAG_W-1:0]   head_tag;
      logic                      is_empty;
      logic                      is_full;
      logic [COUNT_OUT_W-1:0]    entry_count;
   } rsp_word_type;

   typedef struct {
      status_type   status;
      rsp_word_type word;
   } queue_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   bit                    calm = 1'b0;
   int                    mismatch_count = 0;
   entry_type             sorted_entries[$];
   queue_result_type      pending_results[$];

   sorted_insert_priority_queue_unit #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 12);
   end

   // model of the queue contents, ascending score, newest first among ties
   function automatic queue_result_type apply_request(req_kind_type kind, entry_type item);
      queue_result_type res;
      int               pos;
      res.status = ST_DONE;
      if (kind == REQ_INSERT) begin
         if (sorted_entries.size() >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < sorted_entries.size() &&
                   $signed(sorted_entries[pos].score) < $signed(item.score)) begin
               pos++;
            end
            sorted_entries.insert(pos, item);
         end
      end else if (sorted_entries.size() == 0) begin
         res.status = ST_EMPTY;
      end else begin
         void'(sorted_entries.pop_front());
      end
      res.word             = '0;
      res.word.entry_count = COUNT_OUT_W'(sorted_entries.size());
      res.word.is_full     = (sorted_entries.size() == QUEUE_DEPTH);
      res.word.is_empty    = (sorted_entries.size() == 0);
      if (sorted_entries.size() != 0) begin
         res.word.head_tag   = sorted_entries[0].tag;
         res.word.head_score = sorted_entries[0].score;
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [RSP_DATA_W-1:0] want,
                                  logic [RSP_DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endtask

   // predict on each request transfer, compare on each result transfer
   always @(posedge clock) begin : result_check
      entry_type        item;
      queue_result_type want;
      rsp_word_type     got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            item.tag   = req_tdata[TAG_W-1:0];
            item.score = req_tdata[TAG_W +: SCORE_W];
            pending_results.push_back(apply_request(req_kind_type'(req_tuser), item));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", RSP_DATA_W'(want.status), RSP_DATA_W'(rsp_tuser));
               if (got.entry_count !== want.word.entry_count)
                  report_mismatch("entry_count", RSP_DATA_W'(want.word.entry_count),
                                  RSP_DATA_W'(got.entry_count));
               if (got.is_full !== want.word.is_full)
                  report_mismatch("is_full", RSP_DATA_W'(want.word.is_full),
                                  RSP_DATA_W'(got.is_full));
               if (got.is_empty !== want.word.is_empty)
                  report_mismatch("is_empty", RSP_DATA_W'(want.word.is_empty),
                                  RSP_DATA_W'(got.is_empty));
               if (got.head_tag !== want.word.head_tag)
                  report_mismatch("head_tag", RSP_DATA_W'(want.word.head_tag),
                                  RSP_DATA_W'(got.head_tag));
               if (got.head_score !== want.word.head_score)
                  report_mismatch("head_score", RSP_DATA_W'(unsigned'(want.word.head_score)),
                                  RSP_DATA_W'(unsigned'(got.head_score)));
               if (got.pad !== 1'b0)
                  report_mismatch("pad bit", '0, RSP_DATA_W'(got.pad));
            end
         end
      end
   end

   // one request transfer, then at random, unless calm, a pause with valid low
   task automatic send_request(req_kind_type kind, logic [TAG_W-1:0] tag,
                               logic signed [SCORE_W-1:0] score);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {score, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic signed [SCORE_W-1:0] random_score();
      logic signed [SCORE_W-1:0] s;
      case ($urandom_range(3))
         0: begin
            s = SCORE_W'($urandom_range(8));
            s = s - SCORE_W'(4);
         end
         1: s = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
         default: s = SCORE_W'($urandom());
      endcase
      return s;
   endfunction

   task automatic test_remove_from_empty();
      send_request(REQ_REMOVE, 16'hFFFF, 24'sh7FFFFF);
   endtask

   // fills the queue with extremes and with ties of several scores
   task automatic test_ordered_fill();
      logic signed [SCORE_W-1:0] scores[16] = '{
         24'sh000100, 24'sh7FFFFF, 24'sh800000, 24'sh000000,
         24'shFFFFFF, 24'sh000001, 24'sh000100, 24'sh000100,
         24'sh800000, 24'sh7FFFFF, 24'sh000100, 24'sh123456,
         24'shEDCBA9, 24'sh000000, 24'sh800001, 24'sh7FFFFE};
      for (int k = 0; k < 16; k++) begin
         send_request(REQ_INSERT, (k % 2) ? 16'hFFFF : TAG_W'(k * 16'h1111), scores[k]);
      end
   endtask

   task automatic test_insert_when_full();
      send_request(REQ_INSERT, 16'hBEEF, 24'sh800000);
   endtask

   task automatic test_drain_head();
      repeat (7) send_request(REQ_REMOVE, 16'h0000, 24'sh000000);
   endtask

   task automatic test_random_traffic(int items, int insert_pct);
      req_kind_type kind;
      for (int k = 0; k < items; k++) begin
         kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
         send_request(kind, TAG_W'($urandom()), random_score());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_remove_from_empty();
      test_ordered_fill();
      test_insert_when_full();
      test_drain_head();
      test_random_traffic(500, 75);
      test_random_traffic(500, 25);
      calm = 1'b1;
      test_random_traffic(400, 55);
      calm = 1'b0;
      test_random_traffic(600, 50);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
